// ===== src/swbm_pkg.sv =====
// ----------------------------------------------------------------------------
// swbm_pkg
// Shared widths, register indexes, reset values and func codes for the byte rate meter.
// ----------------------------------------------------------------------------
package swbm_pkg;

  localparam int TIME_W   = 32;
  localparam int SIZE_W   = 20;
  localparam int SUM_W    = 32;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // tdata/tuser widths on the stream ports
  localparam int S_TDATA_W = 56;   // time_ms, pkt_size, padded to bytes
  localparam int S_TUSER_W = 2;    // func, direction
  localparam int M_TDATA_W = 64;   // in_bytes, out_bytes
  localparam int M_TUSER_W = 2;    // in_wrapped, out_wrapped

  localparam int RING_DEPTH_DEF = 16384;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 2'd2;

  // Reset values
  localparam logic [CFG_W-1:0] WINDOW_RST   = 16'd1000;
  localparam logic [CFG_W-1:0] INTERVAL_RST = 16'd200;

  // Input func codes
  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

endpackage

// ===== src/sliding_window_bandwidth_meter_unit.sv =====
// ----------------------------------------------------------------------------
// sliding_window_bandwidth_meter_unit
// Sliding-window byte rate meter over two rings of packet records.
// ----------------------------------------------------------------------------
// Sequencing: a record item is done at acceptance (one ring write) and the
// input stays ready. A tick that does not report passes S_CHECK back to S_IDLE.
// A reporting tick runs S_CHECK, then S_RD and S_EV over each ring, visiting
// at least 1 and at most RING_DEPTH - 1 entries per ring, then waits in S_OUT
// for the output register to free up; the shared walk unit reads and sums one entry a cycle.
// The input is held off until the result is loaded into the output register.
// Reset (rst, synchronous): rings read as empty, pointers and last report
// time zero, enable off, window 1000 ms, report interval 200 ms.
module sliding_window_bandwidth_meter_unit
  import swbm_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // slave side
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [31:0] time_ms, [51:32] pkt_size
  input  logic [S_TUSER_W-1:0] s_axis_tuser,   // [0] func, [1] direction
  // master side
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // [31:0] in_bytes, [63:32] out_bytes
  output logic [M_TUSER_W-1:0] m_axis_tuser,   // [0] in_wrapped, [1] out_wrapped
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);
  localparam int ENT_W = TIME_W + SIZE_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;  // interval test, cutoff
  localparam logic [2:0] S_RD    = 3'd2;  // first read of a ring walk
  localparam logic [2:0] S_EV    = 3'd3;  // evaluate one entry, read the next
  localparam logic [2:0] S_OUT   = 3'd4;  // hand result to output register

  function automatic logic [AW-1:0] prev_idx(input logic [AW-1:0] i);
    prev_idx = (i == '0) ? LAST_IDX : i - AW'(1);
  endfunction

  // Input fields
  logic              in_func;
  logic              in_dir;
  logic [TIME_W-1:0] in_time;
  logic [SIZE_W-1:0] in_size;
  assign in_func = s_axis_tuser[0];
  assign in_dir  = s_axis_tuser[1];
  assign in_time = s_axis_tdata[TIME_W-1:0];
  assign in_size = s_axis_tdata[TIME_W +: SIZE_W];

  // Registers
  logic [2:0]        state;
  logic              enable;
  logic [CFG_W-1:0]  window_ms;
  logic [CFG_W-1:0]  interval_ms;
  logic [TIME_W-1:0] last_report;
  logic [AW-1:0]     in_ptr, out_ptr;
  logic              in_full, out_full;   // ring has wrapped since clear
  logic              sel;                 // 0 incoming walk, 1 outgoing walk
  logic [AW-1:0]     idx;
  logic [TIME_W-1:0] tick_time;
  logic [TIME_W-1:0] cutoff;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  in_sum, out_sum;
  logic              in_wrap, out_wrap;

  // Ring storage: {size, timestamp}. Validity comes from pointer and full flag,
  // so a clear is only a pointer and full flag reset.
  logic [ENT_W-1:0]  in_mem  [RING_DEPTH];
  logic [ENT_W-1:0]  out_mem [RING_DEPTH];
  logic [ENT_W-1:0]  in_rd, out_rd;
  logic [AW-1:0]     rd_addr;

  logic in_acc;
  logic rec_wr;
  assign s_axis_tready = (state == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign rec_wr = in_acc && enable && (in_func == FUNC_RECORD);

  // Walk unit: one entry per cycle
  logic [ENT_W-1:0]  ent;
  logic [TIME_W-1:0] ent_ts;
  logic [SIZE_W-1:0] ent_sz;
  logic [AW-1:0]     cur_ptr;
  logic              cur_full;
  logic              ent_valid;
  logic              stop;
  logic [AW-1:0]     nidx;
  logic              hit_ptr;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_sat;
  logic [SUM_W-1:0]  sum_fin;
  logic              ring_done;
  logic              wrap_now;

  assign ent      = sel ? out_rd : in_rd;
  assign ent_ts   = ent[TIME_W-1:0];
  assign ent_sz   = ent[TIME_W +: SIZE_W];
  assign cur_ptr  = sel ? out_ptr : in_ptr;
  assign cur_full = sel ? out_full : in_full;
  assign ent_valid = cur_full || (idx < cur_ptr);
  assign stop     = !ent_valid || (ent_sz == '0) || (ent_ts < cutoff);
  assign nidx     = prev_idx(idx);
  assign hit_ptr  = (nidx == cur_ptr);
  assign sum_add  = {1'b0, sum} + (SUM_W+1)'(ent_sz);
  assign sum_sat  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign sum_fin  = stop ? sum : sum_sat;
  assign ring_done = stop || hit_ptr;
  assign wrap_now = !stop && hit_ptr;
  // In S_EV the next entry is fetched speculatively while this one is judged
  assign rd_addr  = (state == S_EV) ? nidx : idx;

  // Tick check
  logic [TIME_W-1:0] elapsed;
  logic              report;
  logic [TIME_W-1:0] win_ext;
  assign elapsed = tick_time - last_report;
  assign report  = enable && (elapsed > TIME_W'(interval_ms));
  assign win_ext = TIME_W'(window_ms);

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Memories
  always_ff @(posedge clk) begin
    if (rec_wr && !in_dir) begin
      in_mem[in_ptr] <= {in_size, in_time};
    end
    if (rec_wr && in_dir) begin
      out_mem[out_ptr] <= {in_size, in_time};
    end
    in_rd  <= in_mem[rd_addr];
    out_rd <= out_mem[rd_addr];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      enable        <= 1'b0;
      window_ms     <= WINDOW_RST;
      interval_ms   <= INTERVAL_RST;
      last_report   <= '0;
      in_ptr        <= '0;
      out_ptr       <= '0;
      in_full       <= 1'b0;
      out_full      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENABLE: begin
            enable <= cfg_data[0];
            if (cfg_data[0]) begin
              in_ptr   <= '0;
              out_ptr  <= '0;
              in_full  <= 1'b0;
              out_full <= 1'b0;
            end
          end
          REG_WINDOW:   window_ms   <= cfg_data;
          REG_INTERVAL: interval_ms <= cfg_data;
          default: ;
        endcase
      end
      if (rec_wr) begin
        if (!in_dir) begin
          in_ptr <= (in_ptr == LAST_IDX) ? '0 : in_ptr + AW'(1);
          if (in_ptr == LAST_IDX) in_full <= 1'b1;
        end else begin
          out_ptr <= (out_ptr == LAST_IDX) ? '0 : out_ptr + AW'(1);
          if (out_ptr == LAST_IDX) out_full <= 1'b1;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && in_func == FUNC_TICK) state <= S_CHECK;
        end
        S_CHECK: begin
          if (report) begin
            last_report <= tick_time;
            state       <= S_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RD: state <= S_EV;
        S_EV: begin
          if (ring_done) state <= sel ? S_OUT : S_RD;
        end
        S_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (in_acc) tick_time <= in_time;
    if (state == S_CHECK) begin
      cutoff <= (tick_time >= win_ext) ? tick_time - win_ext : '0;
      sel    <= 1'b0;
      idx    <= prev_idx(in_ptr);
      sum    <= '0;
    end
    if (state == S_EV) begin
      if (ring_done) begin
        if (!sel) begin
          in_sum  <= sum_fin;
          in_wrap <= wrap_now;
          sel     <= 1'b1;
          idx     <= prev_idx(out_ptr);
          sum     <= '0;
        end else begin
          out_sum  <= sum_fin;
          out_wrap <= wrap_now;
        end
      end else begin
        sum <= sum_sat;
        idx <= nidx;
      end
    end
    if (state == S_OUT && out_free) begin
      m_axis_tdata <= {out_sum, in_sum};
      m_axis_tuser <= {out_wrap, in_wrap};
    end
  end

endmodule

// ===== src/swbm_checker.sv =====
// ----------------------------------------------------------------------------
// swbm_checker
// Port-level checks for the byte rate meter, bound to the top level.
// ----------------------------------------------------------------------------
module swbm_checker
  import swbm_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TUSER_W-1:0] s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [M_TUSER_W-1:0] m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a record finishes in its acceptance cycle
  a_rec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == FUNC_RECORD |=> s_axis_tready)
    else $error("record item held the input");

  // a tick always needs its check cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == FUNC_TICK |=> !s_axis_tready)
    else $error("tick item did not occupy the sequencer");

  // a full-ring walk only sums non-zero sizes, so the sum is non-zero
  a_wrap_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:0] != '0)
    else $error("incoming wrap with zero bytes");

endmodule

bind sliding_window_bandwidth_meter_unit swbm_checker u_swbm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
